[rtl/cpbf_pkg.sv]
// Closest pair (brute force) package: widths, point and pair types,
// status codes and sequencer states. No dependencies.
package cpbf_pkg;

  localparam int COORD_W        = 16;
  localparam int DIFF_W         = COORD_W + 1;
  localparam int DIST_W         = 2 * COORD_W + 1;
  localparam int STATUS_W       = 2;
  localparam int MAX_POINTS_DEF = 256;
  localparam int IN_DATA_W      = 32;
  localparam int OUT_DATA_W     = 104;

  typedef struct packed {
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] x;
  } point_t;

  typedef struct packed {
    logic [DIST_W-1:0] dist_sq;
    point_t            b;
    point_t            a;
  } pair_t;

  typedef struct packed {
    logic pj_vld;
    logic load_pi;
    logic clear_best;
  } dist_ctl_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK      = 2'd0,
    ST_TOO_FEW = 2'd1,
    ST_DROPPED = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_START,
    S_LOAD_I,
    S_LATCH_I,
    S_SCAN,
    S_DRAIN,
    S_FIN
  } seq_state_t;

endpackage

[rtl/cpbf_store.sv]
// Point store: one write port, one registered read port.
// Depends on cpbf_pkg (point_t).
module cpbf_store import cpbf_pkg::*; #(
  parameter int DEPTH = MAX_POINTS_DEF,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  point_t        wdata,
  input  logic [AW-1:0] raddr,
  output point_t        rdata
);

  point_t mem [DEPTH];
  point_t rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

[rtl/cpbf_dist.sv]
// Shared distance unit: difference, square and compare stages, keeps the best pair.
// Depends on cpbf_pkg (point_t, pair_t, dist_ctl_t).
module cpbf_dist import cpbf_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  dist_ctl_t ctl,
  input  point_t    rd_pt,
  output logic      busy,
  output pair_t     best
);

  point_t                     pi_r;
  logic                       v1_r, v2_r, best_vld_r;
  logic signed [DIFF_W-1:0]   dx_r, dy_r, dx_nxt, dy_nxt;
  point_t                     a1_r, b1_r, a2_r, b2_r;
  logic [DIST_W-1:0]          sqx_r, sqy_r, sum;
  logic signed [2*DIFF_W-1:0] px, py;
  pair_t                      best_r;
  logic                       upd;

  always_comb begin
    dx_nxt = DIFF_W'(pi_r.x) - DIFF_W'(rd_pt.x);
    dy_nxt = DIFF_W'(pi_r.y) - DIFF_W'(rd_pt.y);
    px     = dx_r * dx_r;
    py     = dy_r * dy_r;
    sum    = sqx_r + sqy_r;
    upd    = v2_r && (!best_vld_r || (sum < best_r.dist_sq));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r       <= 1'b0;
      v2_r       <= 1'b0;
      best_vld_r <= 1'b0;
    end else begin
      v1_r <= ctl.pj_vld;
      v2_r <= v1_r;
      if (ctl.clear_best) begin
        best_vld_r <= 1'b0;
      end else if (upd) begin
        best_vld_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load_pi) begin
      pi_r <= rd_pt;
    end
    dx_r  <= dx_nxt;
    dy_r  <= dy_nxt;
    a1_r  <= pi_r;
    b1_r  <= rd_pt;
    sqx_r <= px[DIST_W-1:0];
    sqy_r <= py[DIST_W-1:0];
    a2_r  <= a1_r;
    b2_r  <= b1_r;
    if (upd) begin
      best_r.dist_sq <= sum;
      best_r.a       <= a2_r;
      best_r.b       <= b2_r;
    end
  end

  assign busy = v1_r | v2_r;
  assign best = best_r;

endmodule

[rtl/cpbf_seq.sv]
// Sequencer: collects points, walks the pair scan, orders and holds the result.
// Depends on cpbf_pkg (types, status codes, states).
module cpbf_seq import cpbf_pkg::*; #(
  parameter int MAX_POINTS = MAX_POINTS_DEF,
  localparam int AW        = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1,
  localparam int CW        = $clog2(MAX_POINTS + 1)
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  logic          in_last,
  output logic          st_we,
  output logic [AW-1:0] st_waddr,
  output logic [AW-1:0] st_raddr,
  output dist_ctl_t     ctl,
  input  logic          busy,
  input  pair_t         best,
  output logic          out_valid,
  input  logic          out_ready,
  output pair_t         out_pair,
  output status_t       out_status
);

  seq_state_t        state_r, state_nxt;
  logic [CW-1:0]     n_r, n_nxt;
  logic              ovf_r, ovf_nxt, few_r, few_nxt, pjv_r, pjv_nxt;
  logic [AW-1:0]     i_r, i_nxt, j_r, j_nxt;
  logic              ovld_r, ovld_nxt;
  pair_t             opair_r, opair_nxt;
  status_t           ostat_r, ostat_nxt;
  logic              acc, full, row_end, last_row, out_free, swap;

  always_comb begin
    acc      = in_valid && (state_r == S_IDLE);
    full     = (n_r == CW'(MAX_POINTS));
    row_end  = (CW'(j_r) == n_r - CW'(1));
    last_row = (CW'(i_r) + CW'(2) == n_r);
    out_free = !ovld_r || out_ready;
    swap     = (best.a.x > best.b.x) || ((best.a.x == best.b.x) && (best.a.y > best.b.y));
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:    if (acc && in_last) state_nxt = S_START;
      S_START:   state_nxt = (n_r < CW'(2)) ? S_FIN : S_LOAD_I;
      S_LOAD_I:  state_nxt = S_LATCH_I;
      S_LATCH_I: state_nxt = S_SCAN;
      S_SCAN:    if (row_end) state_nxt = last_row ? S_DRAIN : S_LOAD_I;
      S_DRAIN:   if (!pjv_r && !busy) state_nxt = S_FIN;
      S_FIN:     if (out_free) state_nxt = S_IDLE;
      default:   state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    in_ready       = (state_r == S_IDLE);
    st_we          = acc && !full;
    st_waddr       = n_r[AW-1:0];
    st_raddr       = (state_r == S_LOAD_I) ? i_r : j_r;
    ctl.pj_vld     = pjv_r;
    ctl.load_pi    = (state_r == S_LATCH_I);
    ctl.clear_best = (state_r == S_START);
    n_nxt          = n_r;
    ovf_nxt        = ovf_r;
    few_nxt        = few_r;
    i_nxt          = i_r;
    j_nxt          = j_r;
    pjv_nxt        = 1'b0;
    ovld_nxt       = ovld_r && !out_ready;
    opair_nxt      = opair_r;
    ostat_nxt      = ostat_r;
    case (state_r)
      S_IDLE: begin
        if (acc) begin
          if (full) ovf_nxt = 1'b1;
          else      n_nxt   = n_r + CW'(1);
        end
      end
      S_START: begin
        few_nxt = (n_r < CW'(2));
        i_nxt   = '0;
      end
      S_LOAD_I: j_nxt = i_r + AW'(1);
      S_SCAN: begin
        pjv_nxt = 1'b1;
        if (row_end) i_nxt = i_r + AW'(1);
        else         j_nxt = j_r + AW'(1);
      end
      S_FIN: begin
        if (out_free) begin
          ovld_nxt = 1'b1;
          n_nxt    = '0;
          ovf_nxt  = 1'b0;
          if (few_r) begin
            opair_nxt = '0;
            ostat_nxt = ST_TOO_FEW;
          end else begin
            opair_nxt.dist_sq = best.dist_sq;
            opair_nxt.a       = swap ? best.b : best.a;
            opair_nxt.b       = swap ? best.a : best.b;
            ostat_nxt         = ovf_r ? ST_DROPPED : ST_OK;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      n_r     <= '0;
      ovf_r   <= 1'b0;
      few_r   <= 1'b0;
      pjv_r   <= 1'b0;
      ovld_r  <= 1'b0;
      i_r     <= '0;
      j_r     <= '0;
    end else begin
      state_r <= state_nxt;
      n_r     <= n_nxt;
      ovf_r   <= ovf_nxt;
      few_r   <= few_nxt;
      pjv_r   <= pjv_nxt;
      ovld_r  <= ovld_nxt;
      i_r     <= i_nxt;
      j_r     <= j_nxt;
    end
  end

  always_ff @(posedge clk) begin
    opair_r <= opair_nxt;
    ostat_r <= ostat_nxt;
  end

  assign out_valid  = ovld_r;
  assign out_pair   = opair_r;
  assign out_status = ostat_r;

endmodule

[rtl/closest_pair_brute_force_core.sv]
// Closest pair of points, brute force, squared distance result.
// Depends on cpbf_pkg, cpbf_store, cpbf_dist and cpbf_seq.
//
//  channel | ports            | item
//  --------+------------------+----------------------------------------------
//  in      | in_t{valid,ready,data,last}  | one point; tlast closes the set
//  out     | out_t{valid,ready,data,user} | closest pair, distance, status
//
// Points are taken one a cycle while in_tready is high. After the tlast item,
// each scan row reads point i from the store (S_LOAD_I, S_LATCH_I), then one
// pair enters the distance unit per cycle; the drain follows the last row.
// in_tready is low during the scan; a result waiting on out_tready does not
// block the next set's points. Synchronous active-low reset, no clearing pass.
module closest_pair_brute_force_core import cpbf_pkg::*; #(
  parameter int MAX_POINTS = MAX_POINTS_DEF,
  localparam int AW        = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,   // point_x, point_y
  input  logic                  in_tlast,   // last_point
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,  // first_x, first_y, second_x, second_y,
                                            // squared_distance, zero pad
  output logic [STATUS_W-1:0]   out_tuser   // status
);

  point_t        in_pt, rd_pt;
  logic          st_we, busy;
  logic [AW-1:0] st_waddr, st_raddr;
  dist_ctl_t     ctl;
  pair_t         best, opair;
  status_t       ostat;

  assign in_pt.x = in_tdata[COORD_W-1:0];
  assign in_pt.y = in_tdata[2*COORD_W-1:COORD_W];

  cpbf_store #(.DEPTH(MAX_POINTS)) u_store (
    .clk   (clk),
    .we    (st_we),
    .waddr (st_waddr),
    .wdata (in_pt),
    .raddr (st_raddr),
    .rdata (rd_pt)
  );

  cpbf_dist u_dist (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (ctl),
    .rd_pt (rd_pt),
    .busy  (busy),
    .best  (best)
  );

  cpbf_seq #(.MAX_POINTS(MAX_POINTS)) u_seq (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_tvalid),
    .in_ready   (in_tready),
    .in_last    (in_tlast),
    .st_we      (st_we),
    .st_waddr   (st_waddr),
    .st_raddr   (st_raddr),
    .ctl        (ctl),
    .busy       (busy),
    .best       (best),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_pair   (opair),
    .out_status (ostat)
  );

  assign out_tdata = {(OUT_DATA_W - DIST_W - 4*COORD_W)'(0), opair.dist_sq,
                      opair.b.y, opair.b.x, opair.a.y, opair.a.x};
  assign out_tuser = ostat;

endmodule
